// File: hw/rtl/kp_scan_pkg.sv
// kp_scan_pkg: shared types, register indexes and action decode for the keypad scanner
// no dependencies; used by every module of the keypad scanner
package kp_scan_pkg;

  // configuration register indexes
  localparam logic [7:0] CFG_COLUMN_PERIOD = 8'd0;
  localparam logic [7:0] CFG_DEBOUNCE      = 8'd1;

  // register widths and reset values
  localparam int unsigned CFG_W              = 10;
  localparam logic [9:0]  COLUMN_PERIOD_RST  = 10'd25;
  localparam logic [9:0]  DEBOUNCE_RST       = 10'd100;

  // index widths wide enough for the largest supported matrix (8x8)
  localparam int unsigned IDX_W = 3;

  // stream payload widths
  localparam int unsigned ROW_RISE_W = 4;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_LEFT  = 2'd1,
    ACT_FIRE  = 2'd2,
    ACT_RIGHT = 2'd3
  } action_e;

  // accepted key as found by the row debounce plus the column driven at tick start
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } key_t;

  // game action of a key: A is left, 0 is fire, D is right
  function automatic action_e decode_action(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
    action_e act;
    act = ACT_NONE;
    if (row == 3'd3 && col == 3'd0) act = ACT_LEFT;
    else if (row == 3'd3 && col == 3'd1) act = ACT_FIRE;
    else if (row == 3'd1 && col == 3'd3) act = ACT_RIGHT;
    return act;
  endfunction

endpackage

// File: hw/rtl/kp_scan_debounce.sv
// kp_scan_debounce: per-row retriggerable hold-off counters and accepted row select
// depends on kp_scan_pkg
module kp_scan_debounce #(
  parameter int unsigned ROW_COUNT  = 4,
  parameter int unsigned TIMER_BITS = 10
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  tick_i,
  input  logic [kp_scan_pkg::ROW_RISE_W-1:0]    row_rise_i,
  input  logic [TIMER_BITS-1:0]                 debounce_i,
  output logic                                  found_o,
  output logic [kp_scan_pkg::IDX_W-1:0]         row_o
);

  logic [ROW_COUNT-1:0]  rise;
  logic [TIMER_BITS-1:0] holdoff_q [ROW_COUNT];
  logic [TIMER_BITS-1:0] holdoff_d [ROW_COUNT];
  logic [TIMER_BITS-1:0] holdoff_dec;

  // rows beyond the physical row lines never see an edge
  for (genvar r = 0; r < ROW_COUNT; r++) begin : g_rise
    if (r < kp_scan_pkg::ROW_RISE_W) begin : g_line
      assign rise[r] = row_rise_i[r % kp_scan_pkg::ROW_RISE_W];
    end else begin : g_none
      assign rise[r] = 1'b0;
    end
  end

  // count down, accept an edge on an expired row, reload on every edge
  always_comb begin
    found_o     = 1'b0;
    row_o       = '0;
    holdoff_dec = '0;
    for (int r = 0; r < ROW_COUNT; r++) begin
      holdoff_dec = (holdoff_q[r] != '0) ? holdoff_q[r] - 1'b1 : '0;
      holdoff_d[r] = holdoff_dec;
      if (rise[r]) begin
        if (holdoff_dec == '0) begin
          found_o = 1'b1;
          row_o   = kp_scan_pkg::IDX_W'(r);
        end
        holdoff_d[r] = debounce_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROW_COUNT; r++) holdoff_q[r] <= '0;
    end else if (tick_i) begin
      for (int r = 0; r < ROW_COUNT; r++) holdoff_q[r] <= holdoff_d[r];
    end
  end

endmodule

// File: hw/rtl/kp_scan_column.sv
// kp_scan_column: column rotation counter and current column register
// depends on kp_scan_pkg
module kp_scan_column #(
  parameter int unsigned COLUMN_COUNT = 4,
  parameter int unsigned TIMER_BITS   = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            tick_i,
  input  logic [TIMER_BITS-1:0]           period_i,
  output logic [kp_scan_pkg::IDX_W-1:0]   col_cur_o,
  output logic [kp_scan_pkg::IDX_W-1:0]   col_next_o
);

  localparam int unsigned CW = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
  localparam logic [CW-1:0] LAST_COL = CW'(COLUMN_COUNT - 1);

  logic [CW-1:0]         col_q, col_d;
  logic [TIMER_BITS-1:0] cnt_q, cnt_d;
  logic [TIMER_BITS-1:0] cnt_inc;
  logic [TIMER_BITS-1:0] period;

  // a zero period rotates every tick
  always_comb begin
    period  = (period_i == '0) ? TIMER_BITS'(1) : period_i;
    cnt_inc = cnt_q + 1'b1;
    cnt_d   = cnt_inc;
    col_d   = col_q;
    if (cnt_inc >= period || cnt_inc == '0) begin
      cnt_d = '0;
      col_d = (col_q == LAST_COL) ? '0 : col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      cnt_q <= '0;
    end else if (tick_i) begin
      col_q <= col_d;
      cnt_q <= cnt_d;
    end
  end

  assign col_cur_o  = kp_scan_pkg::IDX_W'(col_q);
  assign col_next_o = kp_scan_pkg::IDX_W'(col_d);

endmodule

// File: hw/rtl/keypad_matrix_scan_debounce.sv
// keypad_matrix_scan_debounce: 4x4 keypad scanner, one result per millisecond tick.
// throughput: one tick per cycle unless the result stream stalls; all per-tick work is one
//   pass of counter and compare logic between the state registers and the output register,
//   which also holds a stalled result; a result appears the cycle after its tick is taken.
// reset (rst_ni low, asynchronous): column 0 driven, counters and hold-offs zero,
//   registers back to period 25 and debounce 100; no clearing pass.
// depends on kp_scan_pkg, kp_scan_debounce, kp_scan_column
module keypad_matrix_scan_debounce #(
  parameter int unsigned ROW_COUNT    = 4,
  parameter int unsigned COLUMN_COUNT = 4,
  parameter int unsigned TIMER_BITS   = 10
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [7:0]                            cfg_index_i,
  input  logic [kp_scan_pkg::CFG_W-1:0]         cfg_data_i,
  // tick input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [kp_scan_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [3:0] row_rise
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [3:0] column_drive, [4] key_valid, [6:5] key_row, [8:7] key_col, [10:9] action
  output logic [kp_scan_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  logic [kp_scan_pkg::CFG_W-1:0]  period_cfg_q, debounce_cfg_q;
  logic [TIMER_BITS-1:0]          period_t, debounce_t;
  logic                           tick;
  logic [kp_scan_pkg::IDX_W-1:0]  col_cur, col_next;
  logic                           row_found;
  logic [kp_scan_pkg::IDX_W-1:0]  row_idx;
  kp_scan_pkg::key_t              key;
  kp_scan_pkg::action_e           act;
  logic [3:0]                     drive;
  logic [kp_scan_pkg::OUT_DATA_W-1:0] out_d;
  logic                           out_valid_q;
  logic [kp_scan_pkg::OUT_DATA_W-1:0] out_data_q;

  // configuration registers, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_cfg_q   <= kp_scan_pkg::COLUMN_PERIOD_RST;
      debounce_cfg_q <= kp_scan_pkg::DEBOUNCE_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == kp_scan_pkg::CFG_COLUMN_PERIOD) period_cfg_q <= cfg_data_i;
      else if (cfg_index_i == kp_scan_pkg::CFG_DEBOUNCE) debounce_cfg_q <= cfg_data_i;
    end
  end

  // register values fitted to the timer width
  if (TIMER_BITS >= kp_scan_pkg::CFG_W) begin : g_ext
    assign period_t   = TIMER_BITS'(period_cfg_q);
    assign debounce_t = TIMER_BITS'(debounce_cfg_q);
  end else begin : g_trunc
    assign period_t   = period_cfg_q[TIMER_BITS-1:0];
    assign debounce_t = debounce_cfg_q[TIMER_BITS-1:0];
  end

  // input transaction advances the state
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign tick          = s_axis_tvalid && s_axis_tready;

  kp_scan_debounce #(
    .ROW_COUNT (ROW_COUNT),
    .TIMER_BITS(TIMER_BITS)
  ) u_debounce (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (tick),
    .row_rise_i(s_axis_tdata[kp_scan_pkg::ROW_RISE_W-1:0]),
    .debounce_i(debounce_t),
    .found_o   (row_found),
    .row_o     (row_idx)
  );

  kp_scan_column #(
    .COLUMN_COUNT(COLUMN_COUNT),
    .TIMER_BITS  (TIMER_BITS)
  ) u_column (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (tick),
    .period_i  (period_t),
    .col_cur_o (col_cur),
    .col_next_o(col_next)
  );

  // result assembly
  always_comb begin
    key.found = row_found;
    key.row   = row_idx;
    key.col   = col_cur;
    act       = kp_scan_pkg::decode_action(key.row, key.col);
    drive     = (col_next < 3'd4) ? 4'(4'b0001 << col_next[1:0]) : 4'b0000;
    out_d     = '0;
    out_d[3:0] = drive;
    if (key.found) begin
      out_d[4]    = 1'b1;
      out_d[6:5]  = key.row[1:0];
      out_d[8:7]  = key.col[1:0];
      out_d[10:9] = act;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) out_data_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  // a tick transaction always leaves a result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni) tick |=> m_axis_tvalid)
    else $error("tick transaction produced no result");

  // at most one column is driven
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[3:0]))
    else $error("more than one column driven");

  // no key means empty key fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[4]) |-> (m_axis_tdata[10:5] == 6'd0))
    else $error("key fields set without a key");

  // a stalled result blocks the next tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("tick taken over a stalled result");
`endif

endmodule

// File: tb/sv/kp_scan_tb_pkg.sv
// kp_scan_tb_pkg: tick-accurate prediction of the keypad scanner and the result checker
// depends on kp_scan_pkg for register indexes, reset values and action codes
`timescale 1ns / 1ps
package kp_scan_tb_pkg;

  // one predicted scan result, fields as they appear in m_axis_tdata
  typedef struct {
    logic [3:0]           column_drive;
    logic                 key_valid;
    logic [1:0]           key_row;
    logic [1:0]           key_col;
    kp_scan_pkg::action_e action;
  } scan_result_t;

  class keypad_scan_checker;
    // configuration copy
    logic [9:0] cfg_period;
    logic [9:0] cfg_holdoff;
    // scanner state copy
    logic [1:0] col_now;
    logic [9:0] col_ticks;
    logic [9:0] row_wait [4];
    // predicted results not yet seen on the output
    scan_result_t pending_scans [$];
    int errors;

    function new();
      cfg_period  = kp_scan_pkg::COLUMN_PERIOD_RST;
      cfg_holdoff = kp_scan_pkg::DEBOUNCE_RST;
      col_now     = '0;
      col_ticks   = '0;
      foreach (row_wait[r]) row_wait[r] = '0;
      errors      = 0;
    endfunction

    // register write as seen by the block; unknown indexes are dropped
    function void set_reg(logic [7:0] idx, logic [9:0] value);
      case (idx)
        kp_scan_pkg::CFG_COLUMN_PERIOD: cfg_period = value;
        kp_scan_pkg::CFG_DEBOUNCE:      cfg_holdoff = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_scans.size();
    endfunction

    // advance the scanner by one accepted tick and queue the predicted result
    function void note_tick(logic [3:0] rise);
      scan_result_t res;
      logic         found;
      logic [1:0]   hit_row;
      logic [1:0]   hit_col;
      logic [9:0]   span;
      int           r;
      found   = 1'b0;
      hit_row = '0;
      hit_col = col_now;
      // hold-offs count down first, then every edge reloads its row
      for (r = 0; r < 4; r++) begin
        if (row_wait[r] != '0) row_wait[r] = row_wait[r] - 10'd1;
        if (rise[r]) begin
          if (row_wait[r] == '0) begin
            found   = 1'b1;
            hit_row = 2'(r);
          end
          row_wait[r] = cfg_holdoff;
        end
      end
      // column rotation, a zero period behaves as one
      span      = (cfg_period == '0) ? 10'd1 : cfg_period;
      col_ticks = col_ticks + 10'd1;
      if (col_ticks >= span || col_ticks == '0) begin
        col_ticks = '0;
        col_now   = col_now + 2'd1;
      end
      res.column_drive = 4'b0001 << col_now;
      res.key_valid    = found;
      res.key_row      = found ? hit_row : 2'd0;
      res.key_col      = found ? hit_col : 2'd0;
      res.action       = kp_scan_pkg::ACT_NONE;
      // keys A, 0 and D give the game actions
      if (found) begin
        case ({hit_row, hit_col})
          4'b11_00: res.action = kp_scan_pkg::ACT_LEFT;
          4'b11_01: res.action = kp_scan_pkg::ACT_FIRE;
          4'b01_11: res.action = kp_scan_pkg::ACT_RIGHT;
          default:  res.action = kp_scan_pkg::ACT_NONE;
        endcase
      end
      pending_scans.push_back(res);
    endfunction

    // compare one output transaction with the oldest prediction
    function void check_scan(logic [15:0] data);
      scan_result_t want;
      if (pending_scans.size() == 0) begin
        $error("scan result 0x%04h with no tick pending", data);
        errors++;
        return;
      end
      want = pending_scans.pop_front();
      if (data[3:0] !== want.column_drive) begin
        $error("column_drive: expected %0d, actual %0d", want.column_drive, data[3:0]);
        errors++;
      end
      if (data[4] !== want.key_valid) begin
        $error("key_valid: expected %0d, actual %0d", want.key_valid, data[4]);
        errors++;
      end
      if (data[6:5] !== want.key_row) begin
        $error("key_row: expected %0d, actual %0d", want.key_row, data[6:5]);
        errors++;
      end
      if (data[8:7] !== want.key_col) begin
        $error("key_col: expected %0d, actual %0d", want.key_col, data[8:7]);
        errors++;
      end
      if (data[10:9] !== 2'(want.action)) begin
        $error("action: expected %0d, actual %0d", want.action, data[10:9]);
        errors++;
      end
    endfunction
  endclass

endpackage

// File: tb/sv/tb.sv
// tb: self-checking testbench of the keypad scanner, directed ticks then bursty random ticks
// depends on kp_scan_pkg, kp_scan_tb_pkg and the keypad_matrix_scan_debounce rtl
`timescale 1ns / 1ps
module tb;

  localparam logic [7:0] CFG_UNUSED_LO = 8'd2;
  localparam logic [7:0] CFG_UNUSED_HI = 8'hFF;
  localparam int         LONG_HOLD     = 300;
  localparam int         CYCLE_LIMIT   = 200000;
  localparam int         PHASES        = 12;
  localparam int         PHASE_TICKS   = 120;

  logic                               clk_i;
  logic                               rst_ni        = 1'b0;
  logic                               cfg_valid_i   = 1'b0;
  logic                               cfg_ready_o;
  logic [7:0]                         cfg_index_i   = '0;
  logic [kp_scan_pkg::CFG_W-1:0]      cfg_data_i    = '0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [kp_scan_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;  // [3:0] row_rise
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  // [3:0] column_drive, [4] key_valid, [6:5] key_row, [8:7] key_col, [10:9] action
  logic [kp_scan_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  int send_idle_pct = 38;
  int recv_idle_pct = 67;
  int hold_requests = 0;
  int cycle_count   = 0;

  kp_scan_tb_pkg::keypad_scan_checker scan_sb = new();

  keypad_matrix_scan_debounce u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // result side: check each transaction, random stalls and requested long hold-offs
  initial begin
    int hold_left;
    int hold_served;
    hold_left   = 0;
    hold_served = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) scan_sb.check_scan(m_axis_tdata);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // offer one tick after a random gap and wait for its transaction
  task automatic send_tick(input logic [3:0] rise);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, rise};
    do @(posedge clk_i); while (!s_axis_tready);
    scan_sb.note_tick(rise);
  endtask

  // drain all results, then write both registers and optionally the unused indexes
  task automatic configure(input logic [9:0] period, input logic [9:0] holdoff,
                           input bit poke_unused);
    logic [7:0] idx [4];
    logic [9:0] val [4];
    int         n;
    int         k;
    idx[0] = kp_scan_pkg::CFG_COLUMN_PERIOD;  val[0] = period;
    idx[1] = kp_scan_pkg::CFG_DEBOUNCE;       val[1] = holdoff;
    idx[2] = CFG_UNUSED_LO;                   val[2] = 10'($urandom);
    idx[3] = CFG_UNUSED_HI;                   val[3] = 10'($urandom);
    n = poke_unused ? 4 : 2;
    s_axis_tvalid <= 1'b0;
    while (scan_sb.pending() != 0) @(posedge clk_i);
    for (k = 0; k < n; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      scan_sb.set_reg(idx[k], val[k]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // stimulus
  initial begin
    logic [3:0] probe [$];
    logic [3:0] rise;
    logic [1:0] burst_row;
    logic [9:0] period;
    logic [9:0] holdoff;
    int         burst_left;
    int         phase;
    int         k;
    burst_left = 0;
    burst_row  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: all rows at once, then an edge inside the hold-off
    probe = '{4'h0, 4'hF, 4'h1};
    foreach (probe[i]) send_tick(probe[i]);

    // column per tick, no debounce: row 3 and row 1 across every column
    configure(10'd1, 10'd0, 1'b0);
    probe = '{4'h8, 4'h8, 4'h8, 4'h8, 4'h2, 4'h2, 4'h2, 4'h2, 4'hF, 4'h0, 4'h5};
    foreach (probe[i]) send_tick(probe[i]);

    // zero period, longest hold-off, writes to indexes past the register list
    configure(10'd0, 10'd1023, 1'b1);
    probe = '{4'h1, 4'h1, 4'h0, 4'hF, 4'h8};
    foreach (probe[i]) send_tick(probe[i]);

    // longest period, one-tick hold-off
    configure(10'd1023, 10'd1, 1'b0);
    probe = '{4'hF, 4'hF, 4'h0, 4'hF};
    foreach (probe[i]) send_tick(probe[i]);

    // random phases: bounce bursts on one row plus occasional noise
    for (phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0:       period = 10'd1;
        1:       period = 10'd0;
        2:       period = 10'd1023;
        default: period = 10'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 5))
        0:       holdoff = 10'd0;
        1:       holdoff = 10'd1023;
        2:       holdoff = 10'($urandom_range(1, 3));
        default: holdoff = 10'($urandom_range(4, 40));
      endcase
      configure(period, holdoff, phase == PHASES / 2);
      if (phase < 4) begin
        send_idle_pct <= 38;
        recv_idle_pct <= 67;
      end else if (phase < 8) begin
        send_idle_pct <= 67;
        recv_idle_pct <= 38;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      // long receiver hold-off while ticks keep coming
      if (phase == 2 || phase == 9) hold_requests <= hold_requests + 1;
      for (k = 0; k < PHASE_TICKS; k++) begin
        if (burst_left == 0 && $urandom_range(0, 9) == 0) begin
          burst_row  = 2'($urandom_range(0, 3));
          burst_left = $urandom_range(1, 6);
        end
        rise = '0;
        if (burst_left > 0) begin
          if ($urandom_range(0, 1) == 1) rise[burst_row] = 1'b1;
          burst_left--;
        end
        if ($urandom_range(0, 19) == 0) rise = rise | 4'($urandom_range(0, 15));
        send_tick(rise);
      end
    end

    // wrap up
    s_axis_tvalid <= 1'b0;
    while (scan_sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (scan_sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/kp_scan_pkg.sv
hw/rtl/kp_scan_debounce.sv
hw/rtl/kp_scan_column.sv
hw/rtl/keypad_matrix_scan_debounce.sv
tb/sv/kp_scan_tb_pkg.sv
tb/sv/tb.sv
